@@ hdl/eqs_pkg.sv @@
// Package for the egress queue selector.
// Holds the state, command and status types and the fixed codes and widths.
// Used by eqs_ctrl, eqs_datapath and egress_queue_selector; depends on nothing.
package eqs_pkg;

    localparam int COUNT_W  = 3;
    localparam int WEIGHT_W = 16;
    localparam int TOTAL_W  = 18;
    localparam int HASH_W   = 32;
    localparam int MODE_W   = 2;
    localparam int QID_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_STEPS  = 32;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_QUEUES      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_ENABLED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ZERO     = 3'd2;

    localparam logic [MODE_W-1:0] MODE_BEST_EFFORT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HASHED      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ROUND_ROBIN = 2'd2;
    localparam logic [MODE_W-1:0] MODE_WEIGHTED    = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } eqs_state_t;

    typedef enum logic [1:0] {
        SEL_NONE,
        SEL_ZERO,
        SEL_MOD,
        SEL_WEIGHTED
    } eqs_sel_t;

    typedef struct packed {
        logic start;
        logic step;
        logic load;
    } eqs_cmd_t;

    typedef struct packed {
        logic shortcut;
        logic div_last;
        logic out_free;
    } eqs_status_t;

endpackage

@@ hdl/eqs_ctrl.sv @@
// Controller of the egress queue selector: accepts a request, runs the
// divider for its fixed step count unless the request needs no division, and
// hands the result to the output stage. Depends on eqs_pkg.
module eqs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  eqs_pkg::eqs_status_t status,
    output eqs_pkg::eqs_cmd_t    cmd
);

    eqs_pkg::eqs_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= eqs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            eqs_pkg::ST_IDLE: begin
                s_axis_tready = aresetn;
                if (s_axis_tvalid && aresetn) begin
                    cmd.start  = 1'b1;
                    state_next = status.shortcut ? eqs_pkg::ST_DONE : eqs_pkg::ST_DIV;
                end
            end
            eqs_pkg::ST_DIV: begin
                cmd.step = 1'b1;
                if (status.div_last) begin
                    state_next = eqs_pkg::ST_DONE;
                end
            end
            eqs_pkg::ST_DONE: begin
                if (status.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = eqs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = eqs_pkg::ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == eqs_pkg::ST_DIV) |-> !s_axis_tready)
        else $error("Request accepted while the divider is busy.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> (state_reg == eqs_pkg::ST_DIV || state_reg == eqs_pkg::ST_DONE))
        else $error("Accepted request did not move the controller forward.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == eqs_pkg::ST_DIV && status.div_last) |=> (state_reg == eqs_pkg::ST_DONE))
        else $error("Divider finished but the controller did not reach the done state.");

endmodule

@@ hdl/eqs_datapath.sv @@
// Datapath of the egress queue selector: configuration registers, weight
// total, ticket counter, restoring divider, queue pick and output register.
// Depends on eqs_pkg; driven by eqs_ctrl.
module eqs_datapath #(
    parameter int MAX_QUEUES = 4
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [eqs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [eqs_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic [eqs_pkg::MODE_W-1:0]            in_mode,
    input  logic [eqs_pkg::HASH_W-1:0]            in_hash,
    input  eqs_pkg::eqs_cmd_t                     cmd,
    output eqs_pkg::eqs_status_t                  status,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [eqs_pkg::QID_W-1:0]             out_queue_id,
    output logic                                  out_no_queue
);

    logic [eqs_pkg::COUNT_W-1:0]  num_queues_reg;
    logic                         weights_enabled_reg;
    logic [eqs_pkg::WEIGHT_W-1:0] weight_reg [MAX_QUEUES];
    logic [eqs_pkg::HASH_W-1:0]   ticket_reg, ticket_next;

    logic [eqs_pkg::COUNT_W-1:0]  active_count;
    logic [eqs_pkg::TOTAL_W-1:0]  cum_weight [MAX_QUEUES];
    logic [eqs_pkg::TOTAL_W-1:0]  weight_total;

    eqs_pkg::eqs_sel_t            sel_kind, kind_reg;
    logic [eqs_pkg::HASH_W-1:0]   dividend_sel, dividend_reg;
    logic [eqs_pkg::TOTAL_W-1:0]  divisor_sel, divisor_reg;
    logic [eqs_pkg::TOTAL_W-1:0]  rem_reg;
    logic [eqs_pkg::TOTAL_W:0]    rem_shift;
    logic [eqs_pkg::STEP_W-1:0]   step_reg;

    logic                         out_valid_reg;
    logic [eqs_pkg::QID_W-1:0]    queue_id_reg, queue_id_next;
    logic                         no_queue_reg;

    assign active_count = (num_queues_reg > eqs_pkg::COUNT_W'(MAX_QUEUES)) ?
                          eqs_pkg::COUNT_W'(MAX_QUEUES) : num_queues_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_queues_reg      <= eqs_pkg::COUNT_W'(1);
            weights_enabled_reg <= 1'b0;
        end else if (cfg_we) begin
            if (cfg_index == eqs_pkg::CFG_NUM_QUEUES) begin
                num_queues_reg <= cfg_wdata[eqs_pkg::COUNT_W-1:0];
            end
            if (cfg_index == eqs_pkg::CFG_WEIGHTS_ENABLED) begin
                weights_enabled_reg <= cfg_wdata[0];
            end
        end
    end

    for (genvar gi = 0; gi < MAX_QUEUES; gi++) begin : g_weight
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                weight_reg[gi] <= eqs_pkg::WEIGHT_W'(1);
            end else if (cfg_we &&
                         cfg_index == eqs_pkg::CFG_WEIGHT_ZERO + eqs_pkg::CFG_IDX_W'(gi)) begin
                weight_reg[gi] <= cfg_wdata;
            end
        end
    end

    // Running sums of the effective weights; a zero weight counts as one.
    always_comb begin
        logic [eqs_pkg::TOTAL_W-1:0] acc;
        acc          = '0;
        weight_total = '0;
        for (int i = 0; i < MAX_QUEUES; i++) begin
            acc = acc + ((weight_reg[i] == '0) ? eqs_pkg::TOTAL_W'(1)
                                               : eqs_pkg::TOTAL_W'(weight_reg[i]));
            cum_weight[i] = acc;
            if (eqs_pkg::COUNT_W'(i) < active_count) begin
                weight_total = acc;
            end
        end
    end

    always_comb begin
        priority if (active_count == '0) begin
            sel_kind = eqs_pkg::SEL_NONE;
        end else if (in_mode == eqs_pkg::MODE_BEST_EFFORT) begin
            sel_kind = eqs_pkg::SEL_ZERO;
        end else if (in_mode == eqs_pkg::MODE_WEIGHTED && weights_enabled_reg) begin
            sel_kind = eqs_pkg::SEL_WEIGHTED;
        end else begin
            sel_kind = eqs_pkg::SEL_MOD;
        end
        dividend_sel = (in_mode == eqs_pkg::MODE_HASHED) ? in_hash : ticket_reg;
        divisor_sel  = (sel_kind == eqs_pkg::SEL_WEIGHTED) ? weight_total
                                                           : eqs_pkg::TOTAL_W'(active_count);
        ticket_next  = ticket_reg;
        if (cmd.start && (sel_kind == eqs_pkg::SEL_WEIGHTED ||
                          (sel_kind == eqs_pkg::SEL_MOD &&
                           in_mode != eqs_pkg::MODE_HASHED))) begin
            ticket_next = ticket_reg + eqs_pkg::HASH_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticket_reg <= '0;
        end else begin
            ticket_reg <= ticket_next;
        end
    end

    assign rem_shift = {rem_reg, dividend_reg[eqs_pkg::HASH_W-1]};

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            kind_reg     <= sel_kind;
            dividend_reg <= dividend_sel;
            divisor_reg  <= divisor_sel;
            rem_reg      <= '0;
            step_reg     <= '0;
        end else if (cmd.step) begin
            dividend_reg <= {dividend_reg[eqs_pkg::HASH_W-2:0], 1'b0};
            step_reg     <= step_reg + eqs_pkg::STEP_W'(1);
            if (rem_shift >= {1'b0, divisor_reg}) begin
                rem_reg <= eqs_pkg::TOTAL_W'(rem_shift - {1'b0, divisor_reg});
            end else begin
                rem_reg <= rem_shift[eqs_pkg::TOTAL_W-1:0];
            end
        end
    end

    // Queue 0, the remainder, or first active queue whose sum exceeds it.
    always_comb begin
        queue_id_next = '0;
        unique case (kind_reg)
            eqs_pkg::SEL_NONE,
            eqs_pkg::SEL_ZERO: begin
                queue_id_next = '0;
            end
            eqs_pkg::SEL_MOD: begin
                queue_id_next = rem_reg[eqs_pkg::QID_W-1:0];
            end
            eqs_pkg::SEL_WEIGHTED: begin
                for (int i = MAX_QUEUES - 1; i >= 0; i--) begin
                    if (eqs_pkg::COUNT_W'(i) < active_count && rem_reg < cum_weight[i]) begin
                        queue_id_next = eqs_pkg::QID_W'(i);
                    end
                end
            end
            default: begin
                queue_id_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            queue_id_reg <= queue_id_next;
            no_queue_reg <= (kind_reg == eqs_pkg::SEL_NONE);
        end
    end

    assign status.shortcut = (sel_kind == eqs_pkg::SEL_NONE || sel_kind == eqs_pkg::SEL_ZERO);
    assign status.div_last = (step_reg == eqs_pkg::STEP_W'(eqs_pkg::DIV_STEPS - 1));
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign out_queue_id = queue_id_reg;
    assign out_no_queue = no_queue_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step || (cmd.start && !status.shortcut)) |-> (divisor_reg != '0 || cmd.start))
        else $error("Divider runs with a zero divisor.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && (kind_reg == eqs_pkg::SEL_MOD || kind_reg == eqs_pkg::SEL_WEIGHTED))
        |-> (rem_reg < divisor_reg))
        else $error("Remainder not below the divisor at the end of the division.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.start |=> $stable(ticket_reg))
        else $error("Ticket counter moved without an accepted request.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && no_queue_reg) |-> (queue_id_reg == '0))
        else $error("A dropped request carries a nonzero queue.");

endmodule

@@ hdl/egress_queue_selector.sv @@
// Top level of the egress queue selector: stream ports and configuration port.
// Instantiates eqs_ctrl and eqs_datapath; depends on eqs_pkg.
//
// Each request on the slave stream carries a policy mode and a 32-bit flow
// hash; the master stream returns one result per request with the selected
// queue and a flag that marks the request as dropped when no queue is active.
// Best-effort requests and requests that find no active queue skip the divider
// and are loaded into the result register once it is free. All other requests
// first run 32 steps of the restoring divider that forms the remainder by the
// queue count or the weight total, and then pick the queue and load the result.
// One request is served at a time; the next is accepted in the cycle after the
// previous result has been loaded, and no request is taken while one is in work.
// The result register holds a finished result while the receiver stalls, and
// the next request may be accepted and computed meanwhile; its result waits,
// and the input stays stalled, until the register is free.
// Configuration writes take effect at the next edge and must only be issued
// while no request is in flight. Synchronous reset restores one active queue,
// weights off, all weights one and a ticket counter of zero.
module egress_queue_selector #(
    parameter int MAX_QUEUES = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [eqs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [eqs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // Fields from bit 0: mode [1:0], hash [33:2], zero padding [39:34].
    input  logic [eqs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // Fields from bit 0: queue_id [1:0], no_queue [2], zero padding [7:3].
    output logic [eqs_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    eqs_pkg::eqs_cmd_t             cmd;
    eqs_pkg::eqs_status_t          status;
    logic [eqs_pkg::QID_W-1:0]     queue_id;
    logic                          no_queue;

    eqs_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    eqs_datapath #(
        .MAX_QUEUES (MAX_QUEUES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_mode      (s_axis_tdata[eqs_pkg::MODE_W-1:0]),
        .in_hash      (s_axis_tdata[eqs_pkg::MODE_W +: eqs_pkg::HASH_W]),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_queue_id (queue_id),
        .out_no_queue (no_queue)
    );

    assign m_axis_tdata = {{(eqs_pkg::OUT_DATA_W - eqs_pkg::QID_W - 1){1'b0}},
                           no_queue, queue_id};

endmodule
